// ===== design/flight_phase_sequencer_macros.svh =====
// Assertion macros for the flight phase sequencer.
// Expects signals clk and rst_n in the module that includes this header.
`ifndef FLIGHT_PHASE_SEQUENCER_MACROS_SVH
`define FLIGHT_PHASE_SEQUENCER_MACROS_SVH

// check consequent in the same cycle
`define FPS_CHECK_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check consequent in the next cycle
`define FPS_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/fps_pkg.sv =====
// Shared types and constants for the flight phase sequencer.
// No dependencies; imported by fps_cfg, fps_seq and flight_phase_sequencer.
`default_nettype none

package fps_pkg;

  typedef enum logic [3:0] {
    PH_TERMINATED = 4'd0,
    PH_SELECTED   = 4'd1,
    PH_ARM        = 4'd2,
    PH_TAKEOFF    = 4'd3,
    PH_UP         = 4'd4,
    PH_MOVE       = 4'd5,
    PH_DOWN       = 4'd6,
    PH_KEEP       = 4'd7,
    PH_UP_BACK    = 4'd8,
    PH_MOVE_BACK  = 4'd9,
    PH_DOWN_BACK  = 4'd10,
    PH_LAND       = 4'd11,
    PH_DISARM     = 4'd12
  } phase_t;

  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_ASSIGN   = 3'd1,
    ACT_REASSIGN = 3'd2,
    ACT_RECALL   = 3'd3,
    ACT_LINK     = 3'd4
  } action_t;

  localparam logic [2:0] CMD_NONE      = 3'd0;
  localparam logic [2:0] CMD_ARM       = 3'd1;
  localparam logic [2:0] CMD_TAKEOFF   = 3'd2;
  localparam logic [2:0] CMD_MOVE      = 3'd3;
  localparam logic [2:0] CMD_SURVEY    = 3'd4;
  localparam logic [2:0] CMD_STOP_MOVE = 3'd5;
  localparam logic [2:0] CMD_LAND      = 3'd6;
  localparam logic [2:0] CMD_DISARM    = 3'd7;

  localparam logic [2:0] SP_NONE       = 3'd0;
  localparam logic [2:0] SP_TGT_2M     = 3'd1;
  localparam logic [2:0] SP_TGT_XY     = 3'd2;
  localparam logic [2:0] SP_TGT_Z      = 3'd3;
  localparam logic [2:0] SP_TGT_1M     = 3'd4;
  localparam logic [2:0] SP_HOME_XY    = 3'd5;
  localparam logic [2:0] SP_HOME_HALF  = 3'd6;
  localparam logic [2:0] SP_GROUND     = 3'd7;

  localparam int AddrWidth = 5;

  localparam logic [2:0] REG_MIN_DWELL     = 3'd0;
  localparam logic [2:0] REG_CONVERGE_HOLD = 3'd1;
  localparam logic [2:0] REG_HANDOVER_WAIT = 3'd2;
  localparam logic [2:0] REG_PERMIT_DIST   = 3'd3;
  localparam logic [2:0] REG_READY_BATTERY = 3'd4;
  localparam logic [2:0] REG_LOW_BATTERY   = 3'd5;

  localparam logic [15:0] MIN_DWELL_RST     = 16'd1000;
  localparam logic [15:0] CONVERGE_HOLD_RST = 16'd2000;
  localparam logic [15:0] HANDOVER_WAIT_RST = 16'd5000;
  localparam logic [15:0] PERMIT_DIST_RST   = 16'd50;
  localparam logic [6:0]  READY_BATTERY_RST = 7'd60;
  localparam logic [6:0]  LOW_BATTERY_RST   = 7'd50;

  typedef struct packed {
    logic [15:0] min_dwell_ms;
    logic [15:0] converge_hold_ms;
    logic [15:0] handover_wait_ms;
    logic [15:0] permit_dist_cm;
    logic [6:0]  ready_battery_pct;
    logic [6:0]  low_battery_pct;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] time_ms;
    logic [15:0] step_dist_cm;
    logic [15:0] ground_dist_cm;
    logic        armed;
    logic [6:0]  battery_pct;
    logic        traffic_clear;
    logic        partner_keeping;
    logic [15:0] partner_dist_cm;
    logic [31:0] partner_elapsed_ms;
  } item_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] command;
    logic [2:0] setpoint_code;
    logic       advanced;
    logic       low_battery;
  } result_t;

  function automatic logic [2:0] command_of(phase_t p);
    logic [2:0] c;
    unique case (p)
      PH_ARM:       c = CMD_ARM;
      PH_TAKEOFF:   c = CMD_TAKEOFF;
      PH_UP:        c = CMD_MOVE;
      PH_MOVE:      c = CMD_MOVE;
      PH_DOWN:      c = CMD_MOVE;
      PH_KEEP:      c = CMD_SURVEY;
      PH_UP_BACK:   c = CMD_STOP_MOVE;
      PH_MOVE_BACK: c = CMD_MOVE;
      PH_DOWN_BACK: c = CMD_MOVE;
      PH_LAND:      c = CMD_LAND;
      PH_DISARM:    c = CMD_DISARM;
      default:      c = CMD_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] setpoint_of(phase_t p);
    logic [2:0] s;
    unique case (p)
      PH_UP:        s = SP_TGT_2M;
      PH_MOVE:      s = SP_TGT_XY;
      PH_DOWN:      s = SP_TGT_Z;
      PH_UP_BACK:   s = SP_TGT_1M;
      PH_MOVE_BACK: s = SP_HOME_XY;
      PH_DOWN_BACK: s = SP_HOME_HALF;
      PH_LAND:      s = SP_GROUND;
      default:      s = SP_NONE;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== design/fps_cfg.sv =====
// APB-style configuration register file of the flight phase sequencer.
// Depends on fps_pkg for the register map, reset values and cfg_t.
`default_nettype none

module fps_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [fps_pkg::AddrWidth-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output fps_pkg::cfg_t                     cfg
);
  import fps_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[AddrWidth-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_dwell_ms      <= MIN_DWELL_RST;
      cfg_r.converge_hold_ms  <= CONVERGE_HOLD_RST;
      cfg_r.handover_wait_ms  <= HANDOVER_WAIT_RST;
      cfg_r.permit_dist_cm    <= PERMIT_DIST_RST;
      cfg_r.ready_battery_pct <= READY_BATTERY_RST;
      cfg_r.low_battery_pct   <= LOW_BATTERY_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MIN_DWELL:     cfg_r.min_dwell_ms      <= pwdata[15:0];
        REG_CONVERGE_HOLD: cfg_r.converge_hold_ms  <= pwdata[15:0];
        REG_HANDOVER_WAIT: cfg_r.handover_wait_ms  <= pwdata[15:0];
        REG_PERMIT_DIST:   cfg_r.permit_dist_cm    <= pwdata[15:0];
        REG_READY_BATTERY: cfg_r.ready_battery_pct <= pwdata[6:0];
        REG_LOW_BATTERY:   cfg_r.low_battery_pct   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MIN_DWELL:     prdata = {16'd0, cfg_r.min_dwell_ms};
      REG_CONVERGE_HOLD: prdata = {16'd0, cfg_r.converge_hold_ms};
      REG_HANDOVER_WAIT: prdata = {16'd0, cfg_r.handover_wait_ms};
      REG_PERMIT_DIST:   prdata = {16'd0, cfg_r.permit_dist_cm};
      REG_READY_BATTERY: prdata = {25'd0, cfg_r.ready_battery_pct};
      REG_LOW_BATTERY:   prdata = {25'd0, cfg_r.low_battery_pct};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/fps_seq.sv =====
// Phase state, dwell and convergence timers, and per-transaction step logic.
// Depends on fps_pkg and flight_phase_sequencer_macros.svh.
`default_nettype none
`include "flight_phase_sequencer_macros.svh"

module fps_seq (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        fire,
  input  fps_pkg::item_t   item,
  input  fps_pkg::cfg_t    cfg,
  output fps_pkg::result_t res
);
  import fps_pkg::*;

  phase_t      phase_r, phase_nxt, phase_succ;
  logic [31:0] entry_r, entry_nxt;
  logic [31:0] cstart_r, cstart_nxt;
  logic        crun_r, crun_nxt;
  logic        linked_r, linked_nxt;

  logic [31:0] dwell_elapsed, conv_elapsed;
  logic        dwell_ok, near, conv_over, conv_fire, conv_phase, conv_touch;
  logic        keep_ok, complete, bat_low;

  assign dwell_elapsed = item.time_ms - entry_r;
  assign conv_elapsed  = item.time_ms - cstart_r;
  assign dwell_ok      = dwell_elapsed >= {16'd0, cfg.min_dwell_ms};
  assign near          = item.step_dist_cm < cfg.permit_dist_cm;
  assign conv_over     = conv_elapsed > {16'd0, cfg.converge_hold_ms};
  assign conv_fire     = near && crun_r && conv_over;
  assign bat_low       = item.battery_pct < cfg.low_battery_pct;
  assign keep_ok       = bat_low && linked_r && item.partner_keeping &&
                         (item.partner_dist_cm < cfg.permit_dist_cm) &&
                         (item.partner_elapsed_ms > {16'd0, cfg.handover_wait_ms});
  assign phase_succ    = (phase_r == PH_DISARM) ? PH_TERMINATED : phase_t'(phase_r + 4'd1);

  always_comb begin
    unique case (phase_r)
      PH_UP, PH_MOVE, PH_DOWN, PH_UP_BACK, PH_MOVE_BACK, PH_DOWN_BACK: conv_phase = 1'b1;
      default: conv_phase = 1'b0;
    endcase
  end

  assign conv_touch = (item.action == ACT_TICK) && dwell_ok && near && conv_phase;

  always_comb begin
    unique case (phase_r)
      PH_SELECTED:               complete = item.battery_pct >= cfg.ready_battery_pct;
      PH_ARM:                    complete = item.armed;
      PH_TAKEOFF:                complete = 1'b1;
      PH_UP, PH_UP_BACK:         complete = conv_fire && item.traffic_clear;
      PH_MOVE, PH_DOWN,
      PH_MOVE_BACK, PH_DOWN_BACK: complete = conv_fire;
      PH_KEEP:                   complete = keep_ok;
      PH_LAND:                   complete = !item.armed ||
                                            (item.ground_dist_cm < cfg.permit_dist_cm);
      PH_DISARM:                 complete = !item.armed;
      default:                   complete = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    entry_nxt  = entry_r;
    cstart_nxt = cstart_r;
    crun_nxt   = crun_r;
    linked_nxt = linked_r;
    unique case (item.action)
      ACT_TICK: begin
        if (phase_r == PH_TERMINATED) begin
          entry_nxt  = item.time_ms;
          linked_nxt = 1'b0;
        end else if (dwell_ok && complete) begin
          phase_nxt = phase_succ;
          entry_nxt = item.time_ms;
          if (phase_r == PH_KEEP) begin
            linked_nxt = 1'b0;
          end
        end
        if (conv_touch) begin
          if (!crun_r) begin
            cstart_nxt = item.time_ms;
            crun_nxt   = 1'b1;
          end else if (conv_over) begin
            crun_nxt = 1'b0;
          end
        end
      end
      ACT_ASSIGN: begin
        phase_nxt = PH_SELECTED;
        entry_nxt = item.time_ms;
        crun_nxt  = 1'b0;
      end
      ACT_REASSIGN: begin
        if (phase_r == PH_UP || phase_r == PH_MOVE || phase_r == PH_DOWN ||
            phase_r == PH_KEEP) begin
          phase_nxt = PH_UP;
        end
        entry_nxt = item.time_ms;
        crun_nxt  = 1'b0;
      end
      ACT_RECALL: begin
        phase_nxt  = PH_UP_BACK;
        linked_nxt = 1'b0;
      end
      ACT_LINK: begin
        linked_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    res.phase         = phase_nxt;
    res.command       = (item.action == ACT_TICK) ? command_of(phase_r) : CMD_NONE;
    res.setpoint_code = (item.action == ACT_TICK) ? setpoint_of(phase_r) : SP_NONE;
    res.advanced      = phase_nxt != phase_r;
    res.low_battery   = (phase_nxt == PH_KEEP) && bat_low && !linked_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TERMINATED;
      entry_r  <= 32'd0;
      cstart_r <= 32'd0;
      crun_r   <= 1'b0;
      linked_r <= 1'b0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      entry_r  <= entry_nxt;
      cstart_r <= cstart_nxt;
      crun_r   <= crun_nxt;
      linked_r <= linked_nxt;
    end
  end

  `FPS_CHECK_NEXT(a_recall, fire && item.action == ACT_RECALL,
                  phase_r == PH_UP_BACK && !linked_r, "recall did not reach up-back")
  `FPS_CHECK_NEXT(a_assign, fire && item.action == ACT_ASSIGN,
                  phase_r == PH_SELECTED && !crun_r, "assign did not reach selected")
  `FPS_CHECK_NEXT(a_hold, !fire,
                  $stable(phase_r) && $stable(entry_r) && $stable(crun_r),
                  "state moved without a transaction")
  `FPS_CHECK_SAME(a_link_low, item.action == ACT_LINK, !res.low_battery,
                  "low battery flagged with partner linked")

endmodule

`default_nettype wire

// ===== design/flight_phase_sequencer.sv =====
// Top level of the flight phase sequencer: input register, step logic, result register.
// Depends on fps_pkg, fps_cfg, fps_seq and flight_phase_sequencer_macros.svh.
//
// One transaction in, one result out. A transaction is captured in the input
// register, evaluated against the phase state once the output register is free
// or being read, and its result lands in the output register. A new
// transaction is taken every cycle while out_ready does not stall the output;
// the phase state register, updated once per transaction, sets that rate.
// in_ready drops only while a result is held by out_ready low and the input
// register is occupied. Six registers sit on the APB-style port at byte
// addresses 0x00 to 0x14 (dwell, converge hold, handover wait, arrival distance,
// ready battery, low battery); write them only while no transaction is in flight.
`default_nettype none
`include "flight_phase_sequencer_macros.svh"

module flight_phase_sequencer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [2:0]                    in_action,
  input  wire logic [31:0]                   in_time_ms,
  input  wire logic [15:0]                   in_step_dist_cm,
  input  wire logic [15:0]                   in_ground_dist_cm,
  input  wire logic                          in_armed,
  input  wire logic [6:0]                    in_battery_pct,
  input  wire logic                          in_traffic_clear,
  input  wire logic                          in_partner_keeping,
  input  wire logic [15:0]                   in_partner_dist_cm,
  input  wire logic [31:0]                   in_partner_elapsed_ms,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [3:0]                         out_phase,
  output logic [2:0]                         out_command,
  output logic [2:0]                         out_setpoint_code,
  output logic                               out_advanced,
  output logic                               out_low_battery,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [fps_pkg::AddrWidth-1:0] cfg_paddr,
  input  wire logic [31:0]                   cfg_pwdata,
  output logic      [31:0]                   cfg_prdata,
  output logic                               cfg_pready
);
  import fps_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  result_t res, res_r;
  logic    in_valid_r, out_valid_r, fire;

  assign cfg_pready = 1'b1;
  assign fire       = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !in_valid_r || fire;

  fps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  fps_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.action             <= in_action;
      item_r.time_ms            <= in_time_ms;
      item_r.step_dist_cm       <= in_step_dist_cm;
      item_r.ground_dist_cm     <= in_ground_dist_cm;
      item_r.armed              <= in_armed;
      item_r.battery_pct        <= in_battery_pct;
      item_r.traffic_clear      <= in_traffic_clear;
      item_r.partner_keeping    <= in_partner_keeping;
      item_r.partner_dist_cm    <= in_partner_dist_cm;
      item_r.partner_elapsed_ms <= in_partner_elapsed_ms;
    end
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_phase         = res_r.phase;
  assign out_command       = res_r.command;
  assign out_setpoint_code = res_r.setpoint_code;
  assign out_advanced      = res_r.advanced;
  assign out_low_battery   = res_r.low_battery;

  `FPS_CHECK_NEXT(a_result_loaded, fire, out_valid_r, "result dropped after evaluation")
  `FPS_CHECK_SAME(a_no_overwrite, out_valid_r && !out_ready, !fire,
                  "result overwritten while stalled")
  `FPS_CHECK_NEXT(a_out_hold, out_valid_r && !out_ready, out_valid_r && $stable(res_r),
                  "result changed while stalled")

endmodule

`default_nettype wire
